// ----- hdl/pcm8rmx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm8rmx_pkg
// Shared types, codes and constants of the resampling effect mixer.
// ----------------------------------------------------------------------------
package pcm8rmx_pkg;

  // Item command codes
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_MIX     = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SOUND_RATE   = 2'd0;
  localparam logic [1:0] CFG_SOUND_LENGTH = 2'd1;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int ADDR_IN_W = 17;
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 16;
  localparam int LEN_W    = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 18;
  localparam int POS_W    = 34;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = 18;

  // Store size default and effect limits
  localparam int STORE_DEPTH_DEF  = 131072;
  localparam int MAX_EFFECT_BYTES = 128 * 1024;

  // Output rate and phase step reciprocal: step = (rate * STEP_RECIP) >> STEP_SHIFT
  // equals floor(rate * 65536 / 22050) exactly for every 16-bit rate.
  localparam int unsigned OUT_RATE_HZ = 22050;
  localparam int          STEP_SHIFT  = 30;
  localparam logic [63:0] RECIP_DIV   = 64'(OUT_RATE_HZ / 2);
  localparam logic [31:0] STEP_RECIP  =
    32'(((64'd1 << (STEP_SHIFT + 15)) + RECIP_DIV - 64'd1) / RECIP_DIV);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(OUT_RATE_HZ);
  localparam logic [STEP_W-1:0] STEP_RESET =
    STEP_W'((64'(RATE_RESET) << FRAC_W) / 64'(OUT_RATE_HZ));

  // Mixing arithmetic
  localparam int EFFECT_BIAS = 128;
  localparam int EFFECT_GAIN = 220;
  localparam int SUM_W       = 20;
  localparam logic signed [SUM_W-1:0] SAT_HIGH = 20'sd32767;
  localparam logic signed [SUM_W-1:0] SAT_LOW  = -20'sd32768;

  // Request handed to the mix datapath when a mix transaction is taken
  typedef struct packed {
    logic load;  // mix transaction accepted this cycle
    logic hit;   // effect still playing for this frame
  } mix_req_t;

endpackage

// ----- hdl/pcm8rmx_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm8rmx_store
// Effect sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcm8rmx_store #(
  parameter int DEPTH  = pcm8rmx_pkg::STORE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(pcm8rmx_pkg::STORE_DEPTH_DEF)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [ADDR_W-1:0]                waddr,
  input  logic [pcm8rmx_pkg::BYTE_W-1:0]   wdata,
  input  logic                             re,
  input  logic [ADDR_W-1:0]                raddr,
  output logic [pcm8rmx_pkg::BYTE_W-1:0]   rdata
);

  logic [pcm8rmx_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [pcm8rmx_pkg::BYTE_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/pcm8rmx_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm8rmx_regs
// Configuration registers: phase step derived from the rate on write, and
// effect length clipped to the store and effect limits.
// ----------------------------------------------------------------------------
module pcm8rmx_regs #(
  parameter int STORE_DEPTH = pcm8rmx_pkg::STORE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pcm8rmx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcm8rmx_pkg::CFG_W-1:0]       cfg_wdata,
  output logic [pcm8rmx_pkg::STEP_W-1:0]      step,
  output logic [pcm8rmx_pkg::LEN_W-1:0]       length
);

  localparam int LEN_CAP_I = (STORE_DEPTH < pcm8rmx_pkg::MAX_EFFECT_BYTES) ?
                             STORE_DEPTH : pcm8rmx_pkg::MAX_EFFECT_BYTES;
  localparam logic [pcm8rmx_pkg::LEN_W-1:0] LEN_CAP = pcm8rmx_pkg::LEN_W'(LEN_CAP_I);
  localparam int PROD_W = pcm8rmx_pkg::RATE_W + 32;

  logic [pcm8rmx_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [pcm8rmx_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [PROD_W-1:0]              prod;
  logic [pcm8rmx_pkg::STEP_W-1:0] step_raw;
  logic [pcm8rmx_pkg::LEN_W-1:0]  len_in;

  // Step by reciprocal multiply; a zero step is bumped to one
  assign prod     = PROD_W'(cfg_wdata[pcm8rmx_pkg::RATE_W-1:0]) *
                    PROD_W'(pcm8rmx_pkg::STEP_RECIP);
  assign step_raw = prod[pcm8rmx_pkg::STEP_SHIFT +: pcm8rmx_pkg::STEP_W];
  assign step_nxt = (step_raw == '0) ? pcm8rmx_pkg::STEP_W'(1) : step_raw;

  // Length saturated to the smaller of the store depth and the effect limit
  assign len_in  = cfg_wdata[pcm8rmx_pkg::LEN_W-1:0];
  assign len_nxt = (len_in > LEN_CAP) ? LEN_CAP : len_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pcm8rmx_pkg::STEP_RESET;
      len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcm8rmx_pkg::CFG_SOUND_RATE:   step_r <= step_nxt;
        pcm8rmx_pkg::CFG_SOUND_LENGTH: len_r  <= len_nxt;
        default: ;
      endcase
    end
  end

  assign step   = step_r;
  assign length = len_r;

endmodule

// ----- hdl/pcm8rmx_mix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm8rmx_mix
// Mix datapath: scales the stored byte, adds the music sample, saturates,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module pcm8rmx_mix (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pcm8rmx_pkg::mix_req_t                  req,
  input  logic signed [pcm8rmx_pkg::SAMPLE_W-1:0] music,
  input  logic [pcm8rmx_pkg::BYTE_W-1:0]         rd_data,
  input  logic                                   out_stall,
  output logic                                   hold,
  output logic                                   out_valid,
  output logic signed [pcm8rmx_pkg::SAMPLE_W-1:0] out_mixed_sample
);

  localparam int SW = pcm8rmx_pkg::SUM_W;

  logic                                   s1_v_r;
  logic                                   s1_hit_r;
  logic signed [pcm8rmx_pkg::SAMPLE_W-1:0] s1_music_r;
  logic                                   out_v_r;
  logic signed [pcm8rmx_pkg::SAMPLE_W-1:0] out_mixed_r, out_mixed_nxt;
  logic                                   out_free;
  logic                                   s1_adv;
  logic signed [8:0]                      centred;
  logic signed [18:0]                     contrib;
  logic signed [SW-1:0]                   sum;

  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign hold     = s1_v_r && !out_free;

  // Effect contribution and saturated sum
  assign centred = $signed({1'b0, rd_data}) - 9'(pcm8rmx_pkg::EFFECT_BIAS);
  assign contrib = s1_hit_r ? (19'(centred) * 19'(pcm8rmx_pkg::EFFECT_GAIN)) : '0;
  assign sum     = SW'(s1_music_r) + SW'(contrib);

  always_comb begin
    if (sum > pcm8rmx_pkg::SAT_HIGH) begin
      out_mixed_nxt = pcm8rmx_pkg::SAMPLE_W'(pcm8rmx_pkg::SAT_HIGH);
    end else if (sum < pcm8rmx_pkg::SAT_LOW) begin
      out_mixed_nxt = pcm8rmx_pkg::SAMPLE_W'(pcm8rmx_pkg::SAT_LOW);
    end else begin
      out_mixed_nxt = sum[pcm8rmx_pkg::SAMPLE_W-1:0];
    end
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (req.load) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      s1_hit_r   <= req.hit;
      s1_music_r <= music;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_mixed_r <= out_mixed_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_mixed_sample = out_mixed_r;

endmodule

// ----- hdl/pcm8_resample_mix_saturate_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm8_resample_mix_saturate_core
// Mixes a stored 8-bit unsigned effect into a 16-bit music stream, stepping
// through the effect with an 18.16 phase accumulator.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | in        | in_valid/in_stall  | cmd, sample_addr, sample_byte, music_sample
//  out_    | out       | out_valid/out_stall| mixed_sample
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// One transaction per cycle while in_stall is low; a taken mix goes through
// the store read, then the saturating add into the output register.
// The play position is updated at acceptance, so mixes follow back to back.
// Reset is synchronous; the store is not cleared and needs no sweep.
// A stalled output backs up one stage, then in_stall rises.
// ----------------------------------------------------------------------------
module pcm8_resample_mix_saturate_core #(
  parameter int STORE_DEPTH = pcm8rmx_pkg::STORE_DEPTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [pcm8rmx_pkg::CMD_W-1:0]            in_cmd,
  input  logic [pcm8rmx_pkg::ADDR_IN_W-1:0]        in_sample_addr,
  input  logic [pcm8rmx_pkg::BYTE_W-1:0]           in_sample_byte,
  input  logic signed [pcm8rmx_pkg::SAMPLE_W-1:0]  in_music_sample,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [pcm8rmx_pkg::SAMPLE_W-1:0]  out_mixed_sample,
  input  logic                                     cfg_we,
  input  logic [pcm8rmx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pcm8rmx_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int IDX_W  = pcm8rmx_pkg::POS_W - pcm8rmx_pkg::FRAC_W;
  localparam int EXT_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  logic [pcm8rmx_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [pcm8rmx_pkg::STEP_W-1:0] step;
  logic [pcm8rmx_pkg::LEN_W-1:0]  length;
  logic                           accept;
  logic                           is_load, is_restart, is_mix;
  logic                           active;
  logic                           addr_ok;
  logic [EXT_W-1:0]               addr_ext, idx_ext;
  logic                           hold;
  pcm8rmx_pkg::mix_req_t          req;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  // Command decode
  always_comb begin
    is_load    = 1'b0;
    is_restart = 1'b0;
    is_mix     = 1'b0;
    unique case (in_cmd)
      pcm8rmx_pkg::CMD_LOAD:    is_load    = 1'b1;
      pcm8rmx_pkg::CMD_RESTART: is_restart = 1'b1;
      pcm8rmx_pkg::CMD_MIX:     is_mix     = 1'b1;
      default: ;
    endcase
  end

  // Playing while the integer part of the position is below the length
  assign active   = pos_r[pcm8rmx_pkg::POS_W-1:pcm8rmx_pkg::FRAC_W] < length;
  assign idx_ext  = EXT_W'(pos_r[pcm8rmx_pkg::POS_W-1:pcm8rmx_pkg::FRAC_W]);
  assign addr_ext = EXT_W'(in_sample_addr);
  assign addr_ok  = addr_ext < EXT_W'(STORE_DEPTH);

  // Phase accumulator
  always_comb begin
    pos_nxt = pos_r;
    if (accept && is_restart) begin
      pos_nxt = '0;
    end else if (accept && is_mix && active) begin
      pos_nxt = pos_r + pcm8rmx_pkg::POS_W'(step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign req.load = accept && is_mix;
  assign req.hit  = active;

  pcm8rmx_regs #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .length    (length)
  );

  logic [pcm8rmx_pkg::BYTE_W-1:0] rd_data;

  pcm8rmx_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (accept && is_load && addr_ok),
    .waddr (addr_ext[ADDR_W-1:0]),
    .wdata (in_sample_byte),
    .re    (req.load),
    .raddr (idx_ext[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  pcm8rmx_mix u_mix (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (req),
    .music            (in_music_sample),
    .rd_data          (rd_data),
    .out_stall        (out_stall),
    .hold             (hold),
    .out_valid        (out_valid),
    .out_mixed_sample (out_mixed_sample)
  );

`ifndef SYNTH
  // Input is only held off by a full, stalled output
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output");

  // Position moves only on restart or a playing mix
  assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && (is_restart || is_mix)) |=> $stable(pos_r))
    else $error("play position moved without a transaction");

  // A finished effect leaves the position alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_mix && !active) |=> $stable(pos_r))
    else $error("play position moved after effect end");

  // Restart clears the position
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_restart) |=> (pos_r == '0))
    else $error("restart did not clear play position");
`endif

endmodule
